[rtl/qdn_pkg.sv]
// Shared types, widths and helpers for the quad downsample / normal renormalize block.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package qdn_pkg;

    localparam int NUM_TEXELS = 4;
    localparam int NUM_CHAN   = 4;
    localparam int NUM_RGB    = 3;
    localparam int CHAN_W     = 8;
    localparam int TEXEL_W    = NUM_CHAN * CHAN_W;
    localparam int IN_W       = NUM_TEXELS * TEXEL_W;
    localparam int OUT_W      = NUM_CHAN * CHAN_W;
    localparam int SUM_W      = CHAN_W + 2;
    localparam int SQ_W       = 2 * CHAN_W;
    localparam int LEN_W      = SQ_W + 2;
    localparam int RHS_W      = 32;
    localparam int LHS_W      = SQ_W + LEN_W;
    localparam int KBITS      = CHAN_W;

    // 255 * 255, scale of the squared right-hand side
    localparam logic [SQ_W:0] RHS_SCALE = 17'd65025;

    // First probe bit of the result search
    localparam logic [CHAN_W-1:0] PROBE_FIRST = 8'h80;

    // Configuration register map
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_NORMALIZE_ADDR = 2'd0;

    typedef logic [NUM_TEXELS-1:0][TEXEL_W-1:0] quad_t;
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0]    texel_t;

    // Payload that travels through the length and search stages
    typedef struct packed {
        logic                                norm;
        texel_t                              avg;
        logic [NUM_RGB-1:0]                  s_neg;
        logic [LEN_W-1:0]                    len_sq;
        logic [NUM_RGB-1:0][RHS_W-1:0]       rhs;
        logic [NUM_RGB-1:0][CHAN_W-1:0]      k;
        logic [CHAN_W-1:0]                   probe;
    } work_t;

    // Magnitude of 2v - 255, always odd
    function automatic logic [CHAN_W-1:0] odd_mag(input logic [CHAN_W-1:0] v);
        return {(v[CHAN_W-1] ? v[CHAN_W-2:0] : ~v[CHAN_W-2:0]), 1'b1};
    endfunction

endpackage

`default_nettype wire

[rtl/qdn_avg.sv]
// Average stage: per-channel truncated mean of the four texels of a quad.
// Depends on qdn_pkg.
`default_nettype none

module qdn_avg
    import qdn_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   adv,
    input  wire logic   in_valid,
    input  wire quad_t  in_quad,
    input  wire logic   in_norm,
    output logic        out_valid,
    output texel_t      out_avg,
    output logic        out_norm
);

    logic   valid_reg;
    logic   valid_next;
    texel_t avg_reg;
    texel_t avg_next;
    logic   norm_reg;
    logic   norm_next;

    // Sum the four values of each channel and drop two bits
    always_comb
    begin
        logic [SUM_W-1:0] sum;
        valid_next = in_valid;
        norm_next  = in_norm;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            sum = '0;
            for (int q = 0; q < NUM_TEXELS; q++)
            begin
                sum = sum + SUM_W'(in_quad[q][CHAN_W*c +: CHAN_W]);
            end
            avg_next[c] = sum[SUM_W-1:2];
        end
    end

    // Advance valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            avg_reg  <= avg_next;
            norm_reg <= norm_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_avg   = avg_reg;
    assign out_norm  = norm_reg;

endmodule

`default_nettype wire

[rtl/qdn_len.sv]
// Length stages: signed components, squared vector length and squared bounds.
// Two register stages; depends on qdn_pkg.
`default_nettype none

module qdn_len
    import qdn_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   adv,
    input  wire logic   in_valid,
    input  wire texel_t in_avg,
    input  wire logic   in_norm,
    output logic        out_valid,
    output work_t       out_work
);

    logic                          sq_valid_reg;
    logic                          sq_valid_next;
    logic [NUM_RGB-1:0][SQ_W-1:0]  sq_reg;
    logic [NUM_RGB-1:0][SQ_W-1:0]  sq_next;
    logic [NUM_RGB-1:0]            neg_reg;
    logic [NUM_RGB-1:0]            neg_next;
    texel_t                        avg_reg;
    logic                          norm_reg;

    logic                          work_valid_reg;
    logic                          work_valid_next;
    work_t                         work_reg;
    work_t                         work_next;

    // Square the magnitude of each component s = 2a - 255
    always_comb
    begin
        logic [CHAN_W-1:0] mag;
        sq_valid_next = in_valid;
        for (int c = 0; c < NUM_RGB; c++)
        begin
            mag         = odd_mag(in_avg[c]);
            neg_next[c] = ~in_avg[c][CHAN_W-1];
            sq_next[c]  = SQ_W'(mag) * SQ_W'(mag);
        end
    end

    // Sum the squares and scale each square by 255^2
    always_comb
    begin
        work_valid_next  = sq_valid_reg;
        work_next.norm   = norm_reg;
        work_next.avg    = avg_reg;
        work_next.s_neg  = neg_reg;
        work_next.len_sq = LEN_W'(sq_reg[0]) + LEN_W'(sq_reg[1]) + LEN_W'(sq_reg[2]);
        for (int c = 0; c < NUM_RGB; c++)
        begin
            work_next.rhs[c] = RHS_W'(sq_reg[c]) * RHS_W'(RHS_SCALE);
            work_next.k[c]   = '0;
        end
        work_next.probe = PROBE_FIRST;
    end

    // Advance valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg   <= 1'b0;
            work_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg   <= sq_valid_next;
            work_valid_reg <= work_valid_next;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg   <= sq_next;
            neg_reg  <= neg_next;
            avg_reg  <= in_avg;
            norm_reg <= in_norm;
            work_reg <= work_next;
        end
    end

    assign out_valid = work_valid_reg;
    assign out_work  = work_reg;

endmodule

`default_nettype wire

[rtl/qdn_bit_step.sv]
// One bit of the result search: try the probe bit on each RGB channel and
// keep it if (2k-255)*sqrt(S) <= 255*s holds. Two register stages; uses qdn_pkg.
`default_nettype none

module qdn_bit_step
    import qdn_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  adv,
    input  wire logic  in_valid,
    input  wire work_t in_work,
    output logic       out_valid,
    output work_t      out_work
);

    logic                           a_valid_reg;
    logic                           a_valid_next;
    work_t                          a_work_reg;
    logic [NUM_RGB-1:0][CHAN_W-1:0] a_cand_reg;
    logic [NUM_RGB-1:0][CHAN_W-1:0] a_cand_next;
    logic [NUM_RGB-1:0][SQ_W-1:0]   a_tsq_reg;
    logic [NUM_RGB-1:0][SQ_W-1:0]   a_tsq_next;

    logic                           b_valid_reg;
    logic                           b_valid_next;
    work_t                          b_work_reg;
    work_t                          b_work_next;

    // Form the candidate and square |2k - 255|
    always_comb
    begin
        logic [CHAN_W-1:0] tm;
        a_valid_next = in_valid;
        for (int c = 0; c < NUM_RGB; c++)
        begin
            a_cand_next[c] = in_work.k[c] | in_work.probe;
            tm             = odd_mag(a_cand_next[c]);
            a_tsq_next[c]  = SQ_W'(tm) * SQ_W'(tm);
        end
    end

    // Compare t^2 * S with u^2 under the signs of t and s
    always_comb
    begin
        logic [LHS_W-1:0] lhs;
        logic [LHS_W-1:0] rhs;
        logic             t_pos;
        logic             fits;
        b_valid_next = a_valid_reg;
        b_work_next  = a_work_reg;
        for (int c = 0; c < NUM_RGB; c++)
        begin
            lhs   = LHS_W'(a_tsq_reg[c]) * LHS_W'(a_work_reg.len_sq);
            rhs   = LHS_W'(a_work_reg.rhs[c]);
            t_pos = a_cand_reg[c][CHAN_W-1];
            if (t_pos)
            begin
                fits = ~a_work_reg.s_neg[c] && (lhs <= rhs);
            end
            else
            begin
                fits = ~a_work_reg.s_neg[c] || (lhs >= rhs);
            end
            b_work_next.k[c] = fits ? a_cand_reg[c] : a_work_reg.k[c];
        end
        b_work_next.probe = a_work_reg.probe >> 1;
    end

    // Advance valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_work_reg <= in_work;
            a_cand_reg <= a_cand_next;
            a_tsq_reg  <= a_tsq_next;
            b_work_reg <= b_work_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_work  = b_work_reg;

endmodule

`default_nettype wire

[rtl/qdn_out.sv]
// Output stage: picks plain or renormalized RGB, holds the result in an output
// register backed by a skid register. Depends on qdn_pkg.
`default_nettype none

module qdn_out
    import qdn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire work_t             in_work,
    output logic                   adv,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata
);

    logic       out_valid_reg;
    logic       out_valid_next;
    texel_t     out_data_reg;
    texel_t     out_data_next;
    logic       skid_valid_reg;
    logic       skid_valid_next;
    texel_t     skid_data_reg;
    texel_t     skid_data_next;
    texel_t     result;
    logic       take;
    logic       in_take;

    // Select the result texel
    always_comb
    begin
        result = in_work.avg;
        if (in_work.norm)
        begin
            for (int c = 0; c < NUM_RGB; c++)
            begin
                result[c] = in_work.k[c];
            end
        end
    end

    assign adv     = ~skid_valid_reg;
    assign take    = out_valid_reg & m_tready;
    assign in_take = in_valid & adv;

    // Refill the output register from skid, then from the pipeline
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_take)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_next  = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

[rtl/quad_downsample_normal_renormalize.sv]
// Top level of the 2x2 mip downsample with optional normal renormalization.
// Instantiates qdn_avg, qdn_len, qdn_bit_step and qdn_out; uses qdn_pkg.
//
// Takes one 2x2 RGBA8 quad per cycle and returns one texel per cycle while the
// pipeline is not held, fully pipelined: a request passes through twenty register
// stages (one average stage, two length stages, eight bit-decision steps of two
// stages each for the exact renormalized search, one output register) before
// m_tvalid rises. A skid register behind the output absorbs one result when
// m_tready drops; s_tready falls only when both are full, and then the whole
// pipeline holds. Register 0 (normalize_normals, byte address 0) selects
// renormalized RGB; alpha is always the truncated average. Write it only while
// the block is idle.
`default_nettype none

module quad_downsample_normal_renormalize
    import qdn_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // texel_top_left [31:0], texel_top_right [63:32],
    // texel_bottom_left [95:64], texel_bottom_right [127:96]
    input  wire logic [IN_W-1:0]       s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,

    // out_red [7:0], out_green [15:8], out_blue [23:16], out_alpha [31:24]
    output logic [OUT_W-1:0]           m_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    logic   norm_reg;
    logic   norm_next;
    logic   adv;

    logic   avg_valid;
    texel_t avg_texel;
    logic   avg_norm;

    logic   step_valid [KBITS+1];
    work_t  step_work  [KBITS+1];

    // Write and read the configuration register
    always_comb
    begin
        norm_next = norm_reg;
        if (psel && penable && pwrite && pready && (paddr == REG_NORMALIZE_ADDR))
        begin
            norm_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_reg <= 1'b0;
        end
        else
        begin
            norm_reg <= norm_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_NORMALIZE_ADDR) ? APB_DATA_W'(norm_reg) : '0;

    assign s_tready = adv;

    // Average the quad
    qdn_avg u_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_quad   (quad_t'(s_tdata)),
        .in_norm   (norm_reg),
        .out_valid (avg_valid),
        .out_avg   (avg_texel),
        .out_norm  (avg_norm)
    );

    // Build the vector length and bounds
    qdn_len u_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (avg_valid),
        .in_avg    (avg_texel),
        .in_norm   (avg_norm),
        .out_valid (step_valid[0]),
        .out_work  (step_work[0])
    );

    // Decide the result bits from the top down
    for (genvar b = 0; b < KBITS; b++)
    begin : g_step
        qdn_bit_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (step_valid[b]),
            .in_work   (step_work[b]),
            .out_valid (step_valid[b+1]),
            .out_work  (step_work[b+1])
        );
    end

    // Select and deliver the result
    qdn_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (step_valid[KBITS]),
        .in_work  (step_work[KBITS]),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
